>>> hdl/linked_list_ranker_defines.svh
// Assertion macros used by the list ranker controller.
`ifndef LINKED_LIST_RANKER_DEFINES_SVH
`define LINKED_LIST_RANKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LLR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/llr_pkg.sv
// Types and constants shared by the list ranker.
package llr_pkg;

	localparam int ID_W   = 32;
	localparam int RANK_W = 12;
	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;

	localparam logic [ID_W-1:0] HEAD_ID = ID_W'(1);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;       // load item accepted: write entry, restart walk
		logic start;      // step item accepted: open search bounds
		logic cmp;        // probe data valid: compare and narrow bounds
		logic fin_found;  // search hit: capture result, advance walk
		logic fin_miss;   // search exhausted: capture not-found result
		logic out_load;   // move captured result into output register
	} llr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic more;  // bounds still enclose at least one entry
		logic hit;   // probed id equals current id
	} llr_stat_t;

endpackage

>>> hdl/llr_if.sv
// Handshake channels of the list ranker: input items, results, configuration.
interface llr_req_if import llr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [IDX_W-1:0] entry_index;
	logic [ID_W-1:0]  node_id;
	logic [ID_W-1:0]  successor_id;

	modport source (output valid, mode, entry_index, node_id, successor_id, input ready);
	modport sink (input valid, mode, entry_index, node_id, successor_id, output ready);
endinterface

interface llr_rsp_if import llr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   ranked_id;
	logic [RANK_W-1:0] rank;
	logic              list_end;
	logic              not_found;

	modport source (output valid, ranked_id, rank, list_end, not_found, input ready);
	modport sink (input valid, ranked_id, rank, list_end, not_found, output ready);
endinterface

interface llr_cfg_if import llr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] node_count;

	modport source (output valid, node_count, input ready);
	modport sink (input valid, node_count, output ready);
endinterface

>>> hdl/llr_ram.sv
// Generic single-port RAM with registered read data.
module llr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/llr_ctrl.sv
// Sequencer of the list ranker: handshakes and search control.
module llr_ctrl import llr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic      req_mode,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  llr_stat_t stat,
	output llr_cmd_t  cmd
);
	`include "linked_list_ranker_defines.svh"

	typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_DONE} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   req_fire;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req_mode == MODE_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						if (!stat.more) begin
							cmd.fin_miss = 1'b1;
							state_nxt    = ST_DONE;
						end else begin
							state_nxt = ST_SEARCH;
						end
					end
				end
			end
			ST_SEARCH: begin
				cmd.cmp = 1'b1;
				if (stat.hit) begin
					cmd.fin_found = 1'b1;
					state_nxt     = ST_DONE;
				end else if (!stat.more) begin
					cmd.fin_miss = 1'b1;
					state_nxt    = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the output register to drain
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LLR_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_q || rsp_ready, "pending result overwritten")
	`LLR_ASSERT_NEXT(a_step_leaves_idle, req_fire && req_mode == MODE_STEP, state_q != ST_IDLE, "step item did not start a search")
	`LLR_ASSERT_NEXT(a_finish_to_done, cmd.fin_found || cmd.fin_miss, state_q == ST_DONE, "finished search not held in done")
	`LLR_ASSERT_SAME(a_valid_after_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result appeared outside done")

endmodule

>>> hdl/llr_dp.sv
// Datapath of the list ranker: table, search bounds, walk state, result registers.
module llr_dp import llr_pkg::*; #(
	parameter int TABLE_DEPTH = 4096,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int BW = AW + 1,
	localparam int CW = (BW > CNT_W) ? BW : CNT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  llr_cmd_t          cmd,
	output llr_stat_t         stat,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [ID_W-1:0]   node_id,
	input  logic [ID_W-1:0]   successor_id,
	input  logic              cfg_wr,
	input  logic [CNT_W-1:0]  cfg_count,
	output logic [ID_W-1:0]   ranked_id,
	output logic [RANK_W-1:0] rank,
	output logic              list_end,
	output logic              not_found
);

	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [CNT_W-1:0]  count_q;
	logic [ID_W-1:0]   cur_id_q;
	logic [RANK_W-1:0] cur_rank_q;
	logic [BW-1:0]     lo_q;
	logic [BW-1:0]     hi_q;    // exclusive upper bound
	logic [AW-1:0]     mid_q;   // address of the probe in flight

	logic [ID_W-1:0]   res_id_q;
	logic [RANK_W-1:0] res_rank_q;
	logic              res_end_q;
	logic              res_nf_q;
	logic [ID_W-1:0]   out_id_q;
	logic [RANK_W-1:0] out_rank_q;
	logic              out_end_q;
	logic              out_nf_q;

	logic [CW-1:0]       cnt_ext;
	logic [CW-1:0]       n_lim;
	logic [BW-1:0]       lo_n;
	logic [BW-1:0]       hi_n;
	logic [BW:0]         sum;
	logic [AW-1:0]       mid_n;
	logic [2*ID_W-1:0]   rdata;
	logic [ID_W-1:0]     probe_id;
	logic [ID_W-1:0]     probe_succ;
	logic                index_ok;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;

	assign cnt_ext    = CW'(count_q);
	assign n_lim      = (cnt_ext > DEPTH_C) ? DEPTH_C : cnt_ext;
	assign probe_id   = rdata[2*ID_W-1:ID_W];
	assign probe_succ = rdata[ID_W-1:0];

	// next bounds: fresh on a new step, narrowed after a compare
	always_comb begin
		if (cmd.start) begin
			lo_n = '0;
			hi_n = BW'(n_lim);
		end else if (probe_id > cur_id_q) begin
			lo_n = lo_q;
			hi_n = {1'b0, mid_q};
		end else begin
			lo_n = {1'b0, mid_q} + BW'(1);
			hi_n = hi_q;
		end
	end

	// midpoint of inclusive bounds lo_n .. hi_n-1
	assign sum   = {1'b0, lo_n} + {1'b0, hi_n} - (BW + 1)'(1);
	assign mid_n = sum[AW:1];

	assign stat.more = (lo_n < hi_n);
	assign stat.hit  = (probe_id == cur_id_q);

	assign index_ok = (CW'(entry_index) < DEPTH_C);
	assign ram_we   = cmd.load && index_ok;
	assign ram_addr = cmd.load ? AW'(entry_index) : mid_n;

	llr_ram #(
		.WIDTH (2 * ID_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({node_id, successor_id}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cur_id_q   <= HEAD_ID;
			cur_rank_q <= '0;
		end else begin
			if (cfg_wr) begin
				count_q <= cfg_count;
			end
			if (cmd.load) begin
				cur_id_q   <= HEAD_ID;
				cur_rank_q <= '0;
			end else if (cmd.fin_found) begin
				cur_id_q   <= probe_succ;
				cur_rank_q <= cur_rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start || cmd.cmp) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
		if (cmd.fin_found || cmd.fin_miss) begin
			res_id_q   <= cur_id_q;
			res_rank_q <= cur_rank_q;
			res_end_q  <= cmd.fin_found && (probe_succ == '0);
			res_nf_q   <= cmd.fin_miss;
		end
		if (cmd.out_load) begin
			out_id_q   <= res_id_q;
			out_rank_q <= res_rank_q;
			out_end_q  <= res_end_q;
			out_nf_q   <= res_nf_q;
		end
	end

	assign ranked_id = out_id_q;
	assign rank      = out_rank_q;
	assign list_end  = out_end_q;
	assign not_found = out_nf_q;

endmodule

>>> hdl/linked_list_ranker.sv
// List ranker: walks a linked list held in a sorted table, one ranked node per step item.
//
// Channels: req carries items. mode 0 loads one (node_id, successor_id) entry at
// entry_index and restarts the walk at id 1, rank 0; mode 1 asks for the next node.
// rsp returns one result per step item: the id searched, its rank, list_end when
// its successor is 0, not_found when the id is absent (the walk then stays put).
// cfg writes node_count, the number of table entries the search covers. It is always
// ready; the user must write it only while the block is idle: the block has no check.
// Search: a step binary-searches the table, one probe per cycle of the single table
// RAM port, over n = min(node_count, TABLE_DEPTH) entries. A hit or a miss is captured
// in the result registers, then moved to the output register; req is then ready again.
// The output register holds a result until rsp.ready; while it is full a new step
// is still accepted and searched, and waits in the datapath until the register drains.
// Reset: walk at id 1 rank 0, node_count 0, no result pending. Table contents are
// undefined until loaded; no clearing pass.
module linked_list_ranker import llr_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input logic     clk,
	input logic     arst_n,
	llr_req_if.sink   req,
	llr_rsp_if.source rsp,
	llr_cfg_if.sink   cfg
);

	llr_cmd_t  cmd;
	llr_stat_t stat;

	assign cfg.ready = 1'b1;

	llr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_mode  (req.mode),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	llr_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.entry_index  (req.entry_index),
		.node_id      (req.node_id),
		.successor_id (req.successor_id),
		.cfg_wr       (cfg.valid),
		.cfg_count    (cfg.node_count),
		.ranked_id    (rsp.ranked_id),
		.rank         (rsp.rank),
		.list_end     (rsp.list_end),
		.not_found    (rsp.not_found)
	);

endmodule
